// ===== hdl/ipf_pkg.sv =====
// Package with shared types, constants and tables for the pitch fusion tip guard.
package ipf_pkg;

   localparam int CordicSteps = 16;
   localparam int StepBits = $clog2(CordicSteps + 1);

   localparam logic signed [23:0] PiQ20 = 24'sd3294199;
   localparam logic [22:0] RateK = 23'd4685083;

   // Register indexes.
   localparam logic [2:0] RegAlpha = 3'd0;
   localparam logic [2:0] RegStep = 3'd1;
   localparam logic [2:0] RegTip = 3'd2;
   localparam logic [2:0] RegRecover = 3'd3;
   localparam logic [2:0] RegScale = 3'd4;

   typedef struct packed {
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [31:0] count_left;
      logic signed [31:0] count_right;
   } req_word_type;

   typedef struct packed {
      logic signed [23:0] pitch_angle;
      logic signed [19:0] pitch_speed;
      logic signed [23:0] speed_left;
      logic signed [23:0] speed_right;
      logic is_tipped;
      logic clear_encoders;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] filter_alpha;
      logic [15:0] step_time;
      logic [21:0] tip_limit;
      logic [21:0] recover_limit;
      logic [15:0] speed_scale;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_ITER, ST_RATE, ST_PRED, ST_MIXA, ST_MIXB,
      ST_SPEED, ST_GUARD, ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep;
      logic iter;
      logic rate;
      logic pred;
      logic mixa;
      logic mixb;
      logic speed;
      logic guard;
   } cmd_type;

   function automatic logic signed [23:0] atan_entry(input logic [StepBits-1:0] i);
      logic signed [23:0] v;
      unique case (i)
         0: v = 24'sd823550;
         1: v = 24'sd486170;
         2: v = 24'sd256879;
         3: v = 24'sd130396;
         4: v = 24'sd65451;
         5: v = 24'sd32757;
         6: v = 24'sd16383;
         7: v = 24'sd8192;
         8: v = 24'sd4096;
         9: v = 24'sd2048;
         10: v = 24'sd1024;
         11: v = 24'sd512;
         12: v = 24'sd256;
         13: v = 24'sd128;
         14: v = 24'sd64;
         15: v = 24'sd32;
         16: v = 24'sd16;
         17: v = 24'sd8;
         18: v = 24'sd4;
         19: v = 24'sd2;
         20: v = 24'sd1;
         21: v = 24'sd1;
         default: v = 24'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [23:0] r;
      if (v > 64'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/ipf_ctrl.sv =====
// Controller state machine that sequences one word through the datapath.
module ipf_ctrl import ipf_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic [StepBits-1:0] step_ff, step_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_PREP;
         ST_PREP: begin
            state_in = ST_ITER;
            step_in = '0;
         end
         ST_ITER: begin
            step_in = step_ff + 1'b1;
            if (step_ff == StepBits'(CordicSteps - 1)) state_in = ST_RATE;
         end
         ST_RATE: state_in = ST_PRED;
         ST_PRED: state_in = ST_MIXA;
         ST_MIXA: state_in = ST_MIXB;
         ST_MIXB: state_in = ST_SPEED;
         ST_SPEED: state_in = ST_GUARD;
         ST_GUARD: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      cmd.load = (state_ff == ST_IDLE) && req_valid;
      cmd.prep = (state_ff == ST_PREP);
      cmd.iter = (state_ff == ST_ITER);
      cmd.rate = (state_ff == ST_RATE);
      cmd.pred = (state_ff == ST_PRED);
      cmd.mixa = (state_ff == ST_MIXA);
      cmd.mixb = (state_ff == ST_MIXB);
      cmd.speed = (state_ff == ST_SPEED);
      cmd.guard = (state_ff == ST_GUARD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   // The datapath keeps its own iteration index, cleared on cmd.prep; step_ff is not passed.
endmodule

// ===== hdl/ipf_datapath.sv =====
// Datapath: CORDIC, filter arithmetic, wheel speeds and the tip guard state.
module ipf_datapath import ipf_pkg::*; (
   input logic clock,
   input logic reset,
   input cmd_type cmd,
   input req_word_type req_word,
   input cfg_type cfg,
   output rsp_word_type rsp_word
);

   req_word_type in_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [24:0] cz_ff;
   logic [StepBits-1:0] idx_ff;
   logic signed [40:0] rate_ff;
   logic signed [26:0] pred_ff;
   logic signed [47:0] mix_ff;
   logic signed [23:0] est_ff, est_in;
   logic [31:0] last_l_ff, last_r_ff;
   logic tip_ff;
   rsp_word_type out_ff;

   logic signed [35:0] x0, y0, dx, dy;
   logic signed [24:0] z0;
   logic signed [63:0] prod_a, prod_b, rnd_v;
   logic signed [40:0] rate_mul;
   logic signed [63:0] spl, spr;
   logic [23:0] mag;
   logic set_v, rel_v;

   // CORDIC pre-rotation.
   always_comb begin
      x0 = 36'(in_ff.accel_z) <<< 16;
      y0 = 36'(in_ff.accel_y) <<< 16;
      z0 = '0;
      if (in_ff.accel_z < 0) begin
         z0 = (in_ff.accel_y >= 0) ? 25'(PiQ20) : -25'(PiQ20);
         x0 = -x0;
         y0 = -y0;
      end
      dx = cy_ff >>> idx_ff;
      dy = cx_ff >>> idx_ff;
   end

   // Multiplies; only prod_b is shared, between the mixa and mixb states.
   assign rate_mul = -(41'(in_ff.gyro_x) * $signed({18'd0, RateK}));
   assign prod_a = rate_ff * $signed({1'b0, cfg.step_time});
   assign rnd_v = prod_a + (64'sd1 <<< 27);
   assign spl = 64'($signed(in_ff.count_left - last_l_ff)) * $signed({1'b0, cfg.speed_scale});
   assign spr = 64'($signed(in_ff.count_right - last_r_ff)) * $signed({1'b0, cfg.speed_scale});
   assign prod_b = cmd.mixa ? 64'(pred_ff) * $signed({1'b0, cfg.filter_alpha})
                            : 64'(-cz_ff) * $signed(18'sd65536 - $signed({2'b0, cfg.filter_alpha}));
   assign est_in = sat24(64'(mix_ff + 48'sd32768) >>> 16);
   assign mag = est_ff[23] ? 24'(-est_ff) : 24'(est_ff);
   assign set_v = tip_ff || ({2'b0, cfg.tip_limit} < mag);
   assign rel_v = set_v && (mag <= {2'b0, cfg.recover_limit});

   always_ff @(posedge clock) begin
      if (cmd.load) in_ff <= req_word;
      if (cmd.prep) begin
         cx_ff <= x0;
         cy_ff <= y0;
         cz_ff <= z0;
         idx_ff <= '0;
      end
      if (cmd.iter && in_ff.accel_y != 0) begin
         idx_ff <= idx_ff + 1'b1;
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + 25'(atan_entry(idx_ff));
         end else begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - 25'(atan_entry(idx_ff));
         end
      end
      if (cmd.rate) begin
         if (in_ff.accel_y == 0) cz_ff <= (in_ff.accel_z < 0) ? 25'(PiQ20) : '0;
         rate_ff <= rate_mul;
      end
      if (cmd.pred) pred_ff <= 27'(est_ff) + 27'(rnd_v >>> 28);
      if (cmd.mixa) mix_ff <= 48'(prod_b);
      if (cmd.mixb) mix_ff <= mix_ff + 48'(prod_b);
      if (cmd.speed) begin
         out_ff.speed_left <= sat24(spl);
         out_ff.speed_right <= sat24(spr);
         out_ff.pitch_speed <= 20'((rate_ff + 41'sd524288) >>> 20);
         est_ff <= est_in;
      end
      if (cmd.guard) begin
         out_ff.pitch_angle <= est_ff;
         out_ff.is_tipped <= set_v && !rel_v;
         out_ff.clear_encoders <= rel_v;
         tip_ff <= set_v && !rel_v;
         last_l_ff <= rel_v ? '0 : in_ff.count_left;
         last_r_ff <= rel_v ? '0 : in_ff.count_right;
      end
      if (reset) begin
         est_ff <= '0;
         last_l_ff <= '0;
         last_r_ff <= '0;
         tip_ff <= 1'b0;
      end
   end

   assign rsp_word = out_ff;
endmodule

// ===== hdl/imu_pitch_fusion_tip_guard_top.sv =====
// Top level of the IMU pitch fusion estimator with tip guard.
// One word runs from acceptance to a valid result through the CORDIC loop,
// run one step per cycle on a single shift-add unit; the next word is taken
// once the result has been delivered.
// Registers: 0 filter_alpha, 1 step_time, 2 tip_limit, 3 recover_limit,
// 4 speed_scale, at byte addresses 4*i; write only while idle.
module imu_pitch_fusion_tip_guard_top import ipf_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input req_word_type req_word,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_word_type rsp_word,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [4:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   cfg_type cfg_ff;
   cmd_type cmd;
   logic [2:0] ridx;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[4:2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_alpha <= 16'd64881;
         cfg_ff.step_time <= 16'd328;
         cfg_ff.tip_limit <= 22'd828375;
         cfg_ff.recover_limit <= 22'd314573;
         cfg_ff.speed_scale <= 16'd26808;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (ridx)
            RegAlpha: cfg_ff.filter_alpha <= csr_pwdata[15:0];
            RegStep: cfg_ff.step_time <= csr_pwdata[15:0];
            RegTip: cfg_ff.tip_limit <= csr_pwdata[21:0];
            RegRecover: cfg_ff.recover_limit <= csr_pwdata[21:0];
            RegScale: cfg_ff.speed_scale <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (ridx)
         RegAlpha: csr_prdata = {16'd0, cfg_ff.filter_alpha};
         RegStep: csr_prdata = {16'd0, cfg_ff.step_time};
         RegTip: csr_prdata = {10'd0, cfg_ff.tip_limit};
         RegRecover: csr_prdata = {10'd0, cfg_ff.recover_limit};
         RegScale: csr_prdata = {16'd0, cfg_ff.speed_scale};
         default: csr_prdata = '0;
      endcase
   end

   ipf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd)
   );

   ipf_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_word(req_word), .cfg(cfg_ff),
      .rsp_word(rsp_word)
   );
endmodule

// ===== hdl/ipf_checker.sv =====
// Port-level checker for the pitch fusion tip guard, bound to the top level.
module ipf_checker import ipf_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_word_type rsp_word
);

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // No new word is taken while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   // A result never appears the cycle after a word is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result too early");

   // A release never coincides with a tipped flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.is_tipped && rsp_word.clear_encoders))
      else $error("tipped and release together");
endmodule

bind imu_pitch_fusion_tip_guard_top ipf_checker u_ipf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
);
